>>> hw/rtl/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg: shared types and constants for the bearing-to-goal angle block
// Angle constants in Q3.13 radians, the CORDIC arctangent table and the
// sequencer state type.
// ----------------------------------------------------------------------------
package bta_pkg;

    // command codes
    localparam logic CMD_POSE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // angle accumulator, signed Q3.13 with headroom
    localparam int ANG_W = 18;
    typedef logic signed [ANG_W-1:0] t_ang;

    localparam t_ang ANG_ZERO         = 18'sd0;
    localparam t_ang ANG_HALF_PI      = 18'sd12868;
    localparam t_ang ANG_PI           = 18'sd25736;
    localparam t_ang ANG_THREE_HALF_PI = 18'sd38604;
    localparam t_ang ANG_TWO_PI       = 18'sd51472;

    // arctangent table depth and the index width that covers it
    localparam int ATAN_LEN = 24;
    localparam int STEP_W   = 5;
    typedef logic [STEP_W-1:0] t_step;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_ITER  = 4'b0100,
        S_FINAL = 4'b1000
    } t_state;

    // atan(2^-i) in Q3.13, rounded to nearest
    function automatic t_ang atan_q13(input t_step idx);
        t_ang v;
        case (idx)
            5'd0:    v = 18'sd6434;
            5'd1:    v = 18'sd3798;
            5'd2:    v = 18'sd2007;
            5'd3:    v = 18'sd1019;
            5'd4:    v = 18'sd511;
            5'd5:    v = 18'sd256;
            5'd6:    v = 18'sd128;
            5'd7:    v = 18'sd64;
            5'd8:    v = 18'sd32;
            5'd9:    v = 18'sd16;
            5'd10:   v = 18'sd8;
            5'd11:   v = 18'sd4;
            5'd12:   v = 18'sd2;
            5'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/bearing_to_goal_angle.sv
// ----------------------------------------------------------------------------
// bearing_to_goal_angle: heading from stored position to a goal point
// Holds the current position; answers heading queries with atan2 by an
// iterative CORDIC, normalized to [0, 2pi) in Q3.13.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken when start is high and busy is low. i_cmd selects the
//   kind: a pose word (CMD_POSE) stores i_point_x/i_point_y as the current
//   position in that edge and gives no result; busy stays low, so another
//   word may follow in the next cycle.
//   A query word (CMD_QUERY) carries a goal point; the vector to it is
//   formed as the word is taken. busy then stays high while the sequencer
//   folds the left half-plane, runs the CORDIC steps one by one through
//   the single shift/add unit and normalizes. The result shows on
//   o_heading with o_valid high for exactly one cycle, the cycle in which
//   busy drops, so a new word can be taken while the result is shown.
//   Vertical and horizontal bearings skip the CORDIC, straight to normalize.
//   The receiver cannot stall: each result is there for one cycle only.
//   Reset (i_rst_n low at a clock edge) clears the position to zero and
//   returns the sequencer to idle; a query in flight is dropped.
// ----------------------------------------------------------------------------
module bearing_to_goal_angle
    import bta_pkg::*;
#(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cmd,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    output logic                   o_valid,
    output logic [15:0]            o_heading
);

    localparam int DW      = COORD_WIDTH + 1;
    localparam int XW      = COORD_WIDTH + 3;
    localparam int N_STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam t_step LAST_STEP = STEP_W'(N_STEPS - 1);

    t_state                  r_state, n_state;
    t_step                   r_step, n_step;
    logic [COORD_WIDTH-1:0]  r_cur_x, r_cur_y;
    logic signed [XW-1:0]    r_x, n_x, r_y, n_y;
    t_ang                    r_z, n_z;
    logic                    r_valid, n_valid;
    logic [15:0]             r_heading, n_heading;

    logic                    accept;
    logic signed [DW-1:0]    dx_in, dy_in;
    logic signed [XW-1:0]    xs, ys;
    t_ang                    z_norm;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign o_valid   = r_valid;
    assign o_heading = r_heading;

    assign dx_in = $signed({1'b0, i_point_x}) - $signed({1'b0, r_cur_x});
    assign dy_in = $signed({1'b0, i_point_y}) - $signed({1'b0, r_cur_y});

    // the shared shift unit
    assign xs = r_x >>> r_step;
    assign ys = r_y >>> r_step;

    always_comb begin
        if (r_z < ANG_ZERO) begin
            z_norm = r_z + ANG_TWO_PI;
        end else if (r_z >= ANG_TWO_PI) begin
            z_norm = r_z - ANG_TWO_PI;
        end else begin
            z_norm = r_z;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_valid   = 1'b0;
        n_heading = r_heading;
        case (r_state)
            S_IDLE: begin
                if (accept && i_cmd == CMD_QUERY) begin
                    n_x     = XW'(dx_in);
                    n_y     = XW'(dy_in);
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_step = '0;
                if (r_x == '0) begin
                    n_z     = (r_y > 0) ? ANG_HALF_PI : ANG_THREE_HALF_PI;
                    n_state = S_FINAL;
                end else if (r_y == '0) begin
                    n_z     = r_x[XW-1] ? ANG_PI : ANG_ZERO;
                    n_state = S_FINAL;
                end else if (r_x[XW-1]) begin
                    // left half-plane: turn by pi first
                    n_x     = -r_x;
                    n_y     = -r_y;
                    n_z     = ANG_PI;
                    n_state = S_ITER;
                end else begin
                    n_z     = ANG_ZERO;
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                if (!r_y[XW-1]) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + atan_q13(r_step);
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - atan_q13(r_step);
                end
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_heading = z_norm[15:0];
                n_valid   = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (accept && i_cmd == CMD_POSE) begin
                r_cur_x <= i_point_x;
                r_cur_y <= i_point_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_heading <= n_heading;
    end

    // a result only ever comes out of the normalize cycle
    a_valid_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_FINAL))
        else $error("result strobe without a normalize cycle");

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_QUERY) |=> busy)
        else $error("query word did not start the sequencer");

    a_pose_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_POSE) |=> !busy && !r_valid)
        else $error("pose word started work or gave a result");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_heading < ANG_TWO_PI[15:0]))
        else $error("heading outside [0, 2pi)");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |-> (r_step <= LAST_STEP))
        else $error("cordic step index past the last step");

endmodule
